@@ design/tgi_pkg.sv @@
// Package: shared constants, register indexes and divider interface types.
`timescale 1ns / 1ps
`default_nettype none
package tgi_pkg;
   localparam int MAX_POINTS_XY_DEF  = 64;
   localparam int MAX_POINTS_ETA_DEF = 32;
   localparam int COMPONENTS_DEF     = 4;

   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int VAL_W     = 32;
   localparam int FRAC_W    = 16;
   localparam int STEP_W    = 24;
   localparam int QUO_W     = 48;
   localparam int PXY_W     = 7;
   localparam int PETA_W    = 6;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [PXY_W-1:0]  POINTS_XY_RST  = 7'd64;
   localparam logic [PETA_W-1:0] POINTS_ETA_RST = 6'd32;
   localparam logic [STEP_W-1:0] STEP_XY_RST    = 24'd65536;
   localparam logic [STEP_W-1:0] STEP_ETA_RST   = 24'd65536;
   localparam logic [VAL_W-1:0]  ORIGIN_XY_RST  = 32'hFFE08000;
   localparam logic [VAL_W-1:0]  ORIGIN_ETA_RST = 32'hFFF00000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POINTS_XY  = 3'd0,
      CSR_POINTS_ETA = 3'd1,
      CSR_STEP_XY    = 3'd2,
      CSR_STEP_ETA   = 3'd3,
      CSR_ORIGIN_XY  = 3'd4,
      CSR_ORIGIN_ETA = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic              start;
      logic [QUO_W-1:0]  dividend;
      logic [STEP_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

@@ design/tgi_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tgi_div import tgi_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [STEP_W-1:0] rem_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [STEP_W-1:0] dvs_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic [STEP_W:0]   trial;
   logic              take;

   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign take  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CNT_W'(1));
         if (div_req.start) begin
            cnt_ff <= CNT_W'(QUO_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dvs_ff <= (div_req.divisor == '0) ? STEP_W'(1) : div_req.divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= take ? STEP_W'(trial - {1'b0, dvs_ff}) : trial[STEP_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], take};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule
`default_nettype wire

@@ design/trilinear_grid_interpolator.sv @@
// Top level: trilinear interpolator over a loaded 3D grid of sample tables.
//
// Input channel req_*: cmd 0 loads one table entry (component, grid_index,
// load_value) and is taken with no result. cmd 1 is a query
// (component, query_x, query_y, query_eta in Q16.16) and gives one result
// item on rsp_* (value, outside_grid).
// A query runs three cell searches, one per axis, on the shared bit-serial
// divider. For a point inside the grid and a valid component, address math
// in ST_IDX1 and ST_IDX2, table reads on the single memory read port and
// blending on one multiplier follow. No new item is taken while a query runs.
// A finished result waits in the output register; the block returns to idle
// once the register is free and takes loads or the next query while the
// result is held under a receiver stall.
// Configuration writes on csr_* are taken at any time.
// Reset sets the registers to their defaults and empties the output; the
// table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module trilinear_grid_interpolator import tgi_pkg::*; #(
   parameter int MAX_POINTS_XY  = MAX_POINTS_XY_DEF,
   parameter int MAX_POINTS_ETA = MAX_POINTS_ETA_DEF,
   parameter int COMPONENTS     = COMPONENTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire logic [1:0]           req_component,
   input  wire logic [16:0]          req_grid_index,
   input  wire logic [31:0]          req_load_value,
   input  wire logic [31:0]          req_query_x,
   input  wire logic [31:0]          req_query_y,
   input  wire logic [31:0]          req_query_eta,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [31:0]               rsp_value,
   output logic                      rsp_outside_grid
);
   localparam int DEPTH   = MAX_POINTS_XY * MAX_POINTS_XY * MAX_POINTS_ETA;
   localparam int FLAT_W  = $clog2(DEPTH);
   localparam int ADDR_W  = $clog2(COMPONENTS * DEPTH);
   localparam int NXY_W   = $clog2(MAX_POINTS_XY + 1);
   localparam int NETA_W  = $clog2(MAX_POINTS_ETA + 1);
   localparam int IX_W    = $clog2(MAX_POINTS_XY);
   localparam int IZ_W    = $clog2(MAX_POINTS_ETA);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_START, ST_DIV_RUN, ST_DIV_END, ST_IDX1, ST_IDX2,
      ST_READ, ST_MUL, ST_ADD, ST_DONE
   } state_type;

   state_type state_ff;

   logic [PXY_W-1:0]  points_xy_ff;
   logic [PETA_W-1:0] points_eta_ff;
   logic [STEP_W-1:0] step_xy_ff, step_eta_ff;
   logic [VAL_W-1:0]  origin_xy_ff, origin_eta_ff;

   logic [NXY_W-1:0]  nxy;
   logic [NETA_W-1:0] neta;

   logic [1:0]  comp_ff;
   logic [31:0] qx_ff, qy_ff, qz_ff;
   logic [1:0]  axis_ff;
   logic        outside_ff;
   logic [IX_W-1:0] ix_ff, iy_ff;
   logic [IZ_W-1:0] iz_ff;
   logic [FRAC_W-1:0] fx_ff, fy_ff, fz_ff;
   logic [FLAT_W-1:0] t_ff, nn_ff, base_ff;
   logic [ADDR_W-1:0] comp_base_ff;
   logic [3:0]  rd_cnt_ff;
   logic        rdv_ff;
   logic [3:0]  cnt_ff;
   logic [2:0]  op_ff;
   logic [31:0] line_ff [8];
   logic [31:0] a_ff;
   logic signed [49:0] prod_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic        rsp_outside_ff;

   logic [VAL_W-1:0] mem [COMPONENTS * DEPTH];
   logic [VAL_W-1:0] mem_q_ff;
   logic             mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [31:0]       coord_sel, origin_sel;
   logic [STEP_W-1:0] step_sel;
   logic [31:0]       nm1_sel;
   logic signed [32:0] coord_delta;
   logic [31:0]       cell_q;
   logic              axis_out;
   logic [FRAC_W-1:0] f_sel;
   logic signed [32:0] diff;
   logic signed [49:0] prod_c;
   logic signed [50:0] sum;
   logic signed [34:0] res35;
   logic [31:0]       res_sat;
   logic              accept;

   assign nxy = (points_xy_ff < PXY_W'(2)) ? NXY_W'(2) :
                (32'(points_xy_ff) > 32'(MAX_POINTS_XY)) ? NXY_W'(MAX_POINTS_XY) :
                NXY_W'(points_xy_ff);
   assign neta = (points_eta_ff < PETA_W'(2)) ? NETA_W'(2) :
                 (32'(points_eta_ff) > 32'(MAX_POINTS_ETA)) ? NETA_W'(MAX_POINTS_ETA) :
                 NETA_W'(points_eta_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         points_xy_ff  <= POINTS_XY_RST;
         points_eta_ff <= POINTS_ETA_RST;
         step_xy_ff    <= STEP_XY_RST;
         step_eta_ff   <= STEP_ETA_RST;
         origin_xy_ff  <= ORIGIN_XY_RST;
         origin_eta_ff <= ORIGIN_ETA_RST;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_POINTS_XY:  points_xy_ff  <= csr_wdata[PXY_W-1:0];
            CSR_POINTS_ETA: points_eta_ff <= csr_wdata[PETA_W-1:0];
            CSR_STEP_XY:    step_xy_ff    <= csr_wdata[STEP_W-1:0];
            CSR_STEP_ETA:   step_eta_ff   <= csr_wdata[STEP_W-1:0];
            CSR_ORIGIN_XY:  origin_xy_ff  <= csr_wdata;
            CSR_ORIGIN_ETA: origin_eta_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // table memory
   assign mem_we    = accept && (req_cmd == CMD_LOAD) &&
                      (32'(req_component) < 32'(COMPONENTS)) &&
                      (32'(req_grid_index) < 32'(DEPTH));
   assign mem_waddr = ADDR_W'(ADDR_W'(req_component) * ADDR_W'(DEPTH)) +
                      ADDR_W'(req_grid_index);
   assign mem_raddr = comp_base_ff + ADDR_W'(base_ff) +
                      (rd_cnt_ff[2] ? ADDR_W'(nxy) : ADDR_W'(0)) +
                      ADDR_W'(rd_cnt_ff[1]) +
                      (rd_cnt_ff[0] ? ADDR_W'(nn_ff) : ADDR_W'(0));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_load_value;
      end
      mem_q_ff <= mem[mem_raddr];
   end

   // axis selection for the cell search
   always_comb begin
      case (axis_ff)
         2'd0: begin
            coord_sel = qx_ff; origin_sel = origin_xy_ff; step_sel = step_xy_ff;
            nm1_sel = 32'(nxy) - 32'd1;
         end
         2'd1: begin
            coord_sel = qy_ff; origin_sel = origin_xy_ff; step_sel = step_xy_ff;
            nm1_sel = 32'(nxy) - 32'd1;
         end
         default: begin
            coord_sel = qz_ff; origin_sel = origin_eta_ff; step_sel = step_eta_ff;
            nm1_sel = 32'(neta) - 32'd1;
         end
      endcase
   end

   assign coord_delta = $signed({coord_sel[31], coord_sel}) -
                        $signed({origin_sel[31], origin_sel});
   assign cell_q = div_rsp.quotient[QUO_W-1:FRAC_W];
   assign axis_out = coord_delta[32] || (cell_q >= nm1_sel);

   assign div_req.start    = (state_ff == ST_DIV_START);
   assign div_req.dividend = {coord_delta[31:0], 16'h0000};
   assign div_req.divisor  = step_sel;

   tgi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // blend unit: a + (b - a) * f, rounded back to Q16.16
   assign f_sel  = (op_ff < 3'd4) ? fz_ff : (op_ff < 3'd6) ? fy_ff : fx_ff;
   assign diff   = $signed({line_ff[1][31], line_ff[1]}) - $signed({line_ff[0][31], line_ff[0]});
   assign prod_c = 50'(diff) * 50'($signed({1'b0, f_sel}));
   assign sum    = $signed({{3{a_ff[31]}}, a_ff, 16'h0000}) + 51'(prod_ff) + 51'sd32768;
   assign res35  = sum[50:16];
   assign res_sat = (res35 > 35'sd2147483647) ? 32'h7FFFFFFF :
                    (res35 < -35'sd2147483648) ? 32'h80000000 : res35[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_cnt_ff    <= '0;
         rdv_ff       <= 1'b0;
         cnt_ff       <= '0;
         op_ff        <= '0;
         axis_ff      <= '0;
         outside_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         rdv_ff <= (state_ff == ST_READ) && !rd_cnt_ff[3];
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_cmd == CMD_QUERY)) begin
                  axis_ff    <= '0;
                  outside_ff <= 1'b0;
                  state_ff   <= ST_DIV_START;
               end
            end
            ST_DIV_START: state_ff <= ST_DIV_RUN;
            ST_DIV_RUN: begin
               if (div_rsp.done) begin
                  state_ff <= ST_DIV_END;
               end
            end
            ST_DIV_END: begin
               outside_ff <= outside_ff || axis_out;
               if (axis_ff == 2'd2) begin
                  if (outside_ff || axis_out ||
                      (32'(comp_ff) >= 32'(COMPONENTS))) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_IDX1;
                  end
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= ST_DIV_START;
               end
            end
            ST_IDX1: state_ff <= ST_IDX2;
            ST_IDX2: begin
               rd_cnt_ff <= '0;
               state_ff  <= ST_READ;
            end
            ST_READ: begin
               if (!rd_cnt_ff[3]) begin
                  rd_cnt_ff <= rd_cnt_ff + 4'd1;
               end else if (!rdv_ff) begin
                  cnt_ff   <= 4'd8;
                  op_ff    <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               cnt_ff   <= cnt_ff - 4'd2;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               cnt_ff <= cnt_ff + 4'd1;
               op_ff  <= op_ff + 3'd1;
               state_ff <= (op_ff == 3'd6) ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept && (req_cmd == CMD_QUERY)) begin
         comp_ff      <= req_component;
         qx_ff        <= req_query_x;
         qy_ff        <= req_query_y;
         qz_ff        <= req_query_eta;
         comp_base_ff <= ADDR_W'(ADDR_W'(req_component) * ADDR_W'(DEPTH));
      end
      if (state_ff == ST_DIV_END) begin
         case (axis_ff)
            2'd0: begin
               ix_ff <= cell_q[IX_W-1:0]; fx_ff <= div_rsp.quotient[FRAC_W-1:0];
            end
            2'd1: begin
               iy_ff <= cell_q[IX_W-1:0]; fy_ff <= div_rsp.quotient[FRAC_W-1:0];
            end
            default: begin
               iz_ff <= cell_q[IZ_W-1:0]; fz_ff <= div_rsp.quotient[FRAC_W-1:0];
            end
         endcase
      end
      if (state_ff == ST_IDX1) begin
         t_ff  <= FLAT_W'(FLAT_W'(ix_ff) * FLAT_W'(nxy)) + FLAT_W'(iy_ff);
         nn_ff <= FLAT_W'(FLAT_W'(nxy) * FLAT_W'(nxy));
      end
      if (state_ff == ST_IDX2) begin
         base_ff <= t_ff + FLAT_W'(nn_ff * FLAT_W'(iz_ff));
      end
      if (rdv_ff) begin
         for (int i = 0; i < 7; i++) begin
            line_ff[i] <= line_ff[i+1];
         end
         line_ff[7] <= mem_q_ff;
      end else if (state_ff == ST_MUL) begin
         a_ff    <= line_ff[0];
         prod_ff <= prod_c;
         for (int i = 0; i < 6; i++) begin
            line_ff[i] <= line_ff[i+2];
         end
      end else if (state_ff == ST_ADD) begin
         line_ff[cnt_ff[2:0]] <= res_sat;
      end
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_outside_ff <= outside_ff;
         rsp_value_ff   <= (outside_ff || (32'(comp_ff) >= 32'(COMPONENTS))) ?
                           32'h0 : line_ff[0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_outside_grid = rsp_outside_ff;

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == CMD_QUERY)) |=> !req_ready)
      else $error("ready high after query start");
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outside_grid) |-> (rsp_value == 32'h0))
      else $error("outside result not zero");
   a_add_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> ($past(state_ff) == ST_MUL))
      else $error("blend add without multiply");
endmodule
`default_nettype wire
